FILE: design/trs_model_matrix_builder_macros.svh
// Assertion macros shared by the checker of the TRS model matrix builder.
`ifndef TRS_MODEL_MATRIX_BUILDER_MACROS_SVH
`define TRS_MODEL_MATRIX_BUILDER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/trs_pkg.sv
// Package with widths, types and entry indexes of the TRS model matrix builder.
`timescale 1ns / 1ps

package trs_pkg;

  localparam int VAL_W       = 32;  // Q16.16 words
  localparam int QUAT_W      = 16;  // Q1.14 quaternion components
  localparam int PROD_W      = 2 * QUAT_W;
  localparam int ROT_W       = PROD_W + 2;  // rotation entries in Q.28 plus headroom
  localparam int ROT_FRAC    = 28;
  localparam int LO_W        = 14;  // low slice of a rotation entry
  localparam int NUM_ENTRIES = 9;
  localparam int NUM_AXES    = 3;
  localparam int NUM_STAGES  = 5;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ROT_W-1:0]  rot_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
  } stage_en_t;

  // Rotation entry indexes, row major.
  localparam int R00 = 0;
  localparam int R01 = 1;
  localparam int R02 = 2;
  localparam int R10 = 3;
  localparam int R11 = 4;
  localparam int R12 = 5;
  localparam int R20 = 6;
  localparam int R21 = 7;
  localparam int R22 = 8;

endpackage

FILE: design/trs_rot_mat.sv
// Two pipeline stages that turn a quaternion into its unnormalized rotation matrix.
`timescale 1ns / 1ps

module trs_rot_mat (
  input  logic                                    clk_i,
  input  trs_pkg::stage_en_t                      en_i,
  input  trs_pkg::quat_t                          quat_w_i,
  input  trs_pkg::quat_t                          quat_x_i,
  input  trs_pkg::quat_t                          quat_y_i,
  input  trs_pkg::quat_t                          quat_z_i,
  output trs_pkg::rot_t [trs_pkg::NUM_ENTRIES-1:0] rot_o
);
  import trs_pkg::*;

  localparam rot_t ROT_ONE = ROT_W'(1) <<< ROT_FRAC;

  prod_t xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  rot_t [NUM_ENTRIES-1:0] rot_d, rot_q;

  function automatic prod_t mul(input quat_t a, input quat_t b);
    prod_t ae, be;
    ae = PROD_W'(a);
    be = PROD_W'(b);
    return ae * be;
  endfunction

  function automatic rot_t ext(input prod_t p);
    return ROT_W'(p);
  endfunction

  // Stage 1: the nine component products.
  always_ff @(posedge clk_i) begin
    if (en_i.st1) begin
      xx_q <= mul(quat_x_i, quat_x_i);
      yy_q <= mul(quat_y_i, quat_y_i);
      zz_q <= mul(quat_z_i, quat_z_i);
      xy_q <= mul(quat_x_i, quat_y_i);
      xz_q <= mul(quat_x_i, quat_z_i);
      yz_q <= mul(quat_y_i, quat_z_i);
      wx_q <= mul(quat_w_i, quat_x_i);
      wy_q <= mul(quat_w_i, quat_y_i);
      wz_q <= mul(quat_w_i, quat_z_i);
    end
  end

  // Stage 2: sums and differences, exact in Q.28.
  always_comb begin
    rot_d[R00] = ROT_ONE - ((ext(yy_q) + ext(zz_q)) <<< 1);
    rot_d[R01] = (ext(xy_q) - ext(wz_q)) <<< 1;
    rot_d[R02] = (ext(xz_q) + ext(wy_q)) <<< 1;
    rot_d[R10] = (ext(xy_q) + ext(wz_q)) <<< 1;
    rot_d[R11] = ROT_ONE - ((ext(xx_q) + ext(zz_q)) <<< 1);
    rot_d[R12] = (ext(yz_q) - ext(wx_q)) <<< 1;
    rot_d[R20] = (ext(xz_q) - ext(wy_q)) <<< 1;
    rot_d[R21] = (ext(yz_q) + ext(wx_q)) <<< 1;
    rot_d[R22] = ROT_ONE - ((ext(xx_q) + ext(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.st2) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

FILE: design/trs_scale_entry.sv
// Three pipeline stages that scale one rotation entry, round it and saturate it.
`timescale 1ns / 1ps

module trs_scale_entry (
  input  logic               clk_i,
  input  trs_pkg::stage_en_t en_i,
  input  trs_pkg::val_t      scale_i,
  input  trs_pkg::rot_t      rot_i,
  output trs_pkg::val_t      res_o
);
  import trs_pkg::*;

  localparam int HI_W  = ROT_W - LO_W;
  localparam int PHI_W = VAL_W + HI_W;
  localparam int PLO_W = VAL_W + LO_W + 1;
  localparam int C_W   = PLO_W + 1;
  localparam int CH_W  = C_W - LO_W;
  localparam int SUM_W = PHI_W + 1;
  localparam int R_W   = SUM_W - (ROT_FRAC - LO_W);

  localparam logic signed [C_W-1:0] RND_HALF = C_W'(1) <<< (ROT_FRAC - 1);
  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic signed [HI_W-1:0]  rot_hi;
  logic signed [LO_W:0]    rot_lo;
  logic signed [PHI_W-1:0] phi_d, phi_q, phi2_q;
  logic signed [PLO_W-1:0] plo_d, plo_q;
  logic signed [C_W-1:0]   c_sum;
  logic signed [CH_W-1:0]  ch_d, ch_q;
  logic signed [SUM_W-1:0] tot;
  logic signed [R_W-1:0]   rnd;
  val_t                    res_d, res_q;

  // Stage 3: the scale times the high and low slices of the entry.
  assign rot_hi = rot_i[ROT_W-1:LO_W];
  assign rot_lo = {1'b0, rot_i[LO_W-1:0]};
  assign phi_d  = PHI_W'(scale_i) * PHI_W'(rot_hi);
  assign plo_d  = PLO_W'(scale_i) * PLO_W'(rot_lo);

  always_ff @(posedge clk_i) begin
    if (en_i.st3) begin
      phi_q <= phi_d;
      plo_q <= plo_d;
    end
  end

  // Stage 4: rounding offset into the low part, then floor of its top bits.
  assign c_sum = C_W'(plo_q) + RND_HALF;
  assign ch_d  = c_sum[C_W-1:LO_W];

  always_ff @(posedge clk_i) begin
    if (en_i.st4) begin
      phi2_q <= phi_q;
      ch_q   <= ch_d;
    end
  end

  // Stage 5: merge the two parts, drop the remaining fraction and saturate.
  assign tot = SUM_W'(phi2_q) + SUM_W'(ch_q);
  assign rnd = tot[SUM_W-1:ROT_FRAC-LO_W];

  always_comb begin
    if (rnd > R_W'(VAL_MAX)) begin
      res_d = VAL_MAX;
    end else if (rnd < R_W'(VAL_MIN)) begin
      res_d = VAL_MIN;
    end else begin
      res_d = rnd[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.st5) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: design/trs_model_matrix_builder.sv
// Top level of the TRS model matrix builder: pipeline control, delay lines and datapath.
`timescale 1ns / 1ps
// Usage:
// A transform word (position, per-axis scale, Q1.14 quaternion) enters on the input
// channel when in_valid_i and in_ready_o are both high. The output channel presents
// the top three rows of M = T*S*R as a word in Q16.16; it is taken when out_valid_o
// and out_ready_i are both high. The bottom row 0,0,0,1 is implied and not driven.
// A word accepted on the input is registered by each stage in turn and shown on the
// output from the last stage. Throughput is one word per cycle while the receiver
// keeps taking words. The rate is set by the five-stage pipeline:
// quaternion products, rotation entries, scale partial products, rounding, merge
// with saturation. Each stage holds a valid bit that moves with its data.
// When the receiver stalls, the last stage holds its word and earlier stages keep
// filling their empty slots, so bubbles are squeezed out; in_ready_o drops only
// when all five stages hold words. Nothing is lost or repeated.
// Reset clears every valid bit; data registers are not reset. The block keeps no
// state between words.
module trs_model_matrix_builder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  trs_pkg::val_t pos_x_i,
  input  trs_pkg::val_t pos_y_i,
  input  trs_pkg::val_t pos_z_i,
  input  trs_pkg::val_t scale_x_i,
  input  trs_pkg::val_t scale_y_i,
  input  trs_pkg::val_t scale_z_i,
  input  trs_pkg::quat_t quat_w_i,
  input  trs_pkg::quat_t quat_x_i,
  input  trs_pkg::quat_t quat_y_i,
  input  trs_pkg::quat_t quat_z_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output trs_pkg::val_t row0_col0_o,
  output trs_pkg::val_t row0_col1_o,
  output trs_pkg::val_t row0_col2_o,
  output trs_pkg::val_t row0_col3_o,
  output trs_pkg::val_t row1_col0_o,
  output trs_pkg::val_t row1_col1_o,
  output trs_pkg::val_t row1_col2_o,
  output trs_pkg::val_t row1_col3_o,
  output trs_pkg::val_t row2_col0_o,
  output trs_pkg::val_t row2_col1_o,
  output trs_pkg::val_t row2_col2_o,
  output trs_pkg::val_t row2_col3_o
);
  import trs_pkg::*;

  logic [NUM_STAGES-1:0] vld_d, vld_q;
  logic [NUM_STAGES-1:0] stg_ld;
  stage_en_t             en;

  val_t [NUM_AXES-1:0]                 pos_in, scale_in;
  val_t [NUM_STAGES-1:0][NUM_AXES-1:0] pos_q;
  val_t [NUM_AXES-1:0]                 scale1_q, scale2_q;
  rot_t [NUM_ENTRIES-1:0]              rot;
  val_t [NUM_ENTRIES-1:0]              res;

  // A stage may load when it is empty or when its word moves on in the same cycle.
  always_comb begin
    stg_ld[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stg_ld[k] = !vld_q[k] || stg_ld[k+1];
    end
  end

  assign en.st1 = stg_ld[0];
  assign en.st2 = stg_ld[1];
  assign en.st3 = stg_ld[2];
  assign en.st4 = stg_ld[3];
  assign en.st5 = stg_ld[4];

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (stg_ld[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = stg_ld[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  assign pos_in   = {pos_z_i, pos_y_i, pos_x_i};
  assign scale_in = {scale_z_i, scale_y_i, scale_x_i};

  // The position rides along all five stages; the scale meets its rotation row at stage 3.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (stg_ld[k]) begin
        pos_q[k] <= (k == 0) ? pos_in : pos_q[(k == 0) ? 0 : k - 1];
      end
    end
    if (en.st1) begin
      scale1_q <= scale_in;
    end
    if (en.st2) begin
      scale2_q <= scale1_q;
    end
  end

  trs_rot_mat u_rot_mat (
    .clk_i    (clk_i),
    .en_i     (en),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .rot_o    (rot)
  );

  // One scaling lane per matrix entry; entry e belongs to row e / NUM_AXES.
  for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_entry
    trs_scale_entry u_entry (
      .clk_i   (clk_i),
      .en_i    (en),
      .scale_i (scale2_q[e / NUM_AXES]),
      .rot_i   (rot[e]),
      .res_o   (res[e])
    );
  end

  assign row0_col0_o = res[R00];
  assign row0_col1_o = res[R01];
  assign row0_col2_o = res[R02];
  assign row1_col0_o = res[R10];
  assign row1_col1_o = res[R11];
  assign row1_col2_o = res[R12];
  assign row2_col0_o = res[R20];
  assign row2_col1_o = res[R21];
  assign row2_col2_o = res[R22];
  assign row0_col3_o = pos_q[NUM_STAGES-1][0];
  assign row1_col3_o = pos_q[NUM_STAGES-1][1];
  assign row2_col3_o = pos_q[NUM_STAGES-1][2];

endmodule

FILE: design/trs_chk.sv
// Port-level checker of the TRS model matrix builder and its bind statement.
`timescale 1ns / 1ps
`include "trs_model_matrix_builder_macros.svh"

module trs_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input trs_pkg::val_t row0_col0_o,
  input trs_pkg::val_t row0_col3_o,
  input trs_pkg::val_t row1_col1_o,
  input trs_pkg::val_t row2_col2_o
);

  // A waiting result word stays offered.
  `TRS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output word dropped")

  // A waiting result word keeps its value.
  `TRS_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
    $stable(row0_col0_o) && $stable(row0_col3_o) && $stable(row1_col1_o) &&
    $stable(row2_col2_o), "output word changed while stalled")

  // With the receiver taking words, every stage can advance, so input is open.
  `TRS_ASSERT(a_ready_flow, !out_ready_i || in_ready_o, "input blocked without a stall")

  // An accepted word reaches the output after passing every stage when nothing stalls.
  `TRS_ASSERT_NEXT(a_latency,
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i, out_valid_o, "word missing after pipeline latency")

endmodule

bind trs_model_matrix_builder trs_chk u_trs_chk (.*);
